// ----- rtl/dht_pkg.sv -----
// Shared types and constants for the double-hashing table core.
`timescale 1ns / 1ps
`default_nettype none

package dht_pkg;

   localparam int KeyW         = 31;
   localparam int ValueW       = 31;
   localparam int SlotW        = 10;
   localparam int StatusW      = 2;
   localparam int ReduceStages = 3;
   localparam int QueueDepth   = 2;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [StatusW-1:0] STAT_OK     = 2'd0;
   localparam logic [StatusW-1:0] STAT_ABSENT = 2'd1;
   localparam logic [StatusW-1:0] STAT_FULL   = 2'd2;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [KeyW-1:0]   key;
      logic [ValueW-1:0] value;
   } dht_req_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [ValueW-1:0]  value_out;
      logic [SlotW-1:0]   slot;
   } dht_rsp_type;

   typedef struct packed {
      logic              valid;
      logic [KeyW-1:0]   key;
      logic [ValueW-1:0] value;
   } dht_entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } dht_state_type;

endpackage

`default_nettype wire

// ----- rtl/dht_mod_reduce.sv -----
// Three-stage remainder by a constant divisor using a reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module dht_mod_reduce import dht_pkg::*; #(
   parameter int DIVISOR = 1009,
   localparam int RW = $clog2(DIVISOR)
) (
   input  logic            clock,
   input  logic            enable,
   input  logic [KeyW-1:0] dividend,
   output logic [RW-1:0]   remainder
);

   localparam int          Shift     = KeyW + $clog2(DIVISOR);
   localparam logic [63:0] RecipWide = (64'd1 << Shift) / 64'(DIVISOR);
   localparam logic [31:0] Recip     = RecipWide[31:0];
   localparam logic [15:0] Div       = 16'(DIVISOR);

   logic [62:0]     prod_ff, prod_in;
   logic [KeyW-1:0] num1_ff, num1_in;
   logic [KeyW-1:0] num2_ff, num2_in;
   logic [46:0]     qd_ff, qd_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [KeyW-1:0] quot;
   logic [KeyW-1:0] diff;

   always_comb begin
      prod_in = 63'(dividend) * 63'(Recip);
      num1_in = dividend;
      quot    = KeyW'(prod_ff >> Shift);
      qd_in   = 47'(quot) * 47'(Div);
      num2_in = num1_ff;
      diff    = num2_ff - qd_ff[KeyW-1:0];
      // estimate is low by at most one
      if (diff >= KeyW'(DIVISOR)) begin
         rem_in = RW'(diff - KeyW'(DIVISOR));
      end else begin
         rem_in = RW'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         num1_ff <= num1_in;
         qd_ff   <= qd_in;
         num2_ff <= num2_in;
         rem_ff  <= rem_in;
      end
   end

   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/dht_front.sv -----
// Front end: accept requests and compute home slot and probe step.
`timescale 1ns / 1ps
`default_nettype none

module dht_front import dht_pkg::*; #(
   parameter int TABLE_SLOTS = 1009,
   parameter int STEP_PRIME  = 997,
   localparam int IW   = $clog2(TABLE_SLOTS),
   localparam int SW   = $clog2(STEP_PRIME),
   localparam int JobW = $bits(dht_req_type) + 2 * IW
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            clearing,
   input  logic            req_valid,
   output logic            req_stall,
   input  dht_req_type     req_payload,
   input  logic            queue_full,
   output logic            job_push,
   output logic [JobW-1:0] job_data
);

   localparam int FrontStages = 2 * ReduceStages;
   localparam int LastStage   = FrontStages - 1;
   localparam int LastHome    = ReduceStages - 1;

   logic                   adv;
   logic                   accept;
   logic [FrontStages-1:0] vld_ff, vld_in;
   dht_req_type            req_pipe_ff [FrontStages];
   dht_req_type            req_pipe_in [FrontStages];
   logic [IW-1:0]          home_pipe_ff [ReduceStages];
   logic [IW-1:0]          home_pipe_in [ReduceStages];
   logic [IW-1:0]          home_rem;
   logic [SW-1:0]          step_rem;
   logic [IW-1:0]          step_red;
   logic [KeyW-1:0]        stride;

   assign adv       = !(vld_ff[LastStage] && queue_full);
   assign accept    = req_valid && !clearing && adv;
   assign req_stall = clearing || !adv;
   assign stride    = KeyW'(step_rem) + KeyW'(1);

   always_comb begin
      vld_in = {vld_ff[FrontStages-2:0], accept};
      req_pipe_in[0] = req_payload;
      for (int i = 1; i < FrontStages; i++) begin
         req_pipe_in[i] = req_pipe_ff[i-1];
      end
      home_pipe_in[0] = home_rem;
      for (int i = 1; i < ReduceStages; i++) begin
         home_pipe_in[i] = home_pipe_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         req_pipe_ff  <= req_pipe_in;
         home_pipe_ff <= home_pipe_in;
      end
   end

   dht_mod_reduce #(.DIVISOR(TABLE_SLOTS)) u_home (
      .clock     (clock),
      .enable    (adv),
      .dividend  (req_payload.key),
      .remainder (home_rem)
   );

   dht_mod_reduce #(.DIVISOR(STEP_PRIME)) u_step (
      .clock     (clock),
      .enable    (adv),
      .dividend  (req_payload.key),
      .remainder (step_rem)
   );

   dht_mod_reduce #(.DIVISOR(TABLE_SLOTS)) u_wrap (
      .clock     (clock),
      .enable    (adv),
      .dividend  (stride),
      .remainder (step_red)
   );

   assign job_push = vld_ff[LastStage] && !queue_full;
   assign job_data = {req_pipe_ff[LastStage], home_pipe_ff[LastHome], step_red};

endmodule

`default_nettype wire

// ----- rtl/dht_queue.sv -----
// Two-entry job queue between front end and table engine.
`timescale 1ns / 1ps
`default_nettype none

module dht_queue import dht_pkg::*; #(
   parameter int WIDTH = 84
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int            PW         = $clog2(QueueDepth);
   localparam int            CW         = $clog2(QueueDepth + 1);
   localparam logic [PW-1:0] LastPtr    = PW'(QueueDepth - 1);
   localparam logic [CW-1:0] DepthCount = CW'(QueueDepth);

   logic [WIDTH-1:0] entry_ff [QueueDepth];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == DepthCount);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset) pop |-> (count_ff != '0))
      else $error("queue pop while empty");

   assert property (@(posedge clock) disable iff (reset) push |-> (count_ff != DepthCount))
      else $error("queue push while full");

endmodule

`default_nettype wire

// ----- rtl/dht_back.sv -----
// Table engine: probe the slot memory one slot per cycle and build the response.
`timescale 1ns / 1ps
`default_nettype none

module dht_back import dht_pkg::*; #(
   parameter int TABLE_SLOTS = 1009,
   localparam int IW   = $clog2(TABLE_SLOTS),
   localparam int ReqW = $bits(dht_req_type),
   localparam int JobW = ReqW + 2 * IW
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   input  logic [JobW-1:0] job_data,
   output logic            job_pop,
   output logic            clearing,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output dht_rsp_type     rsp_payload
);

   localparam logic [IW-1:0] LastSlot  = IW'(TABLE_SLOTS - 1);
   localparam logic [IW:0]   SlotLimit = (IW + 1)'(TABLE_SLOTS);

   dht_entry_type slot_mem [TABLE_SLOTS];
   dht_entry_type rd_data_ff;

   dht_state_type state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] home_ff, home_in;
   logic [IW-1:0] step_ff, step_in;
   dht_req_type   req_ff, req_in;
   dht_rsp_type   res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   dht_rsp_type   rsp_data_ff, rsp_data_in;

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   dht_entry_type mem_wdata;
   logic [IW-1:0] mem_raddr;

   dht_req_type   job_req;
   logic [IW:0]   step_sum;
   logic [IW-1:0] next_idx;
   logic          wrapped;

   assign job_req = dht_req_type'(job_data[JobW-1 -: ReqW]);

   always_comb begin
      step_sum = {1'b0, idx_ff} + {1'b0, step_ff};
      if (step_sum >= SlotLimit) begin
         next_idx = IW'(step_sum - SlotLimit);
      end else begin
         next_idx = IW'(step_sum);
      end
      wrapped = (next_idx == home_ff);
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      home_in      = home_ff;
      step_in      = step_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = '{valid: 1'b1, key: req_ff.key, value: req_ff.value};
      mem_raddr    = idx_ff;
      job_pop      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + IW'(1);
            if (clr_ff == LastSlot) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (job_valid) begin
               job_pop   = 1'b1;
               req_in    = job_req;
               home_in   = job_data[2*IW-1:IW];
               step_in   = job_data[IW-1:0];
               idx_in    = job_data[2*IW-1:IW];
               mem_raddr = job_data[2*IW-1:IW];
               res_in    = '{status: STAT_ABSENT, value_out: '0, slot: '0};
               if (job_req.opcode == OP_NOP) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (req_ff.opcode == OP_INSERT) begin
               if (!rd_data_ff.valid) begin
                  mem_we   = 1'b1;
                  res_in   = '{status: STAT_OK, value_out: '0, slot: SlotW'(idx_ff)};
                  state_in = ST_DONE;
               end else if (wrapped) begin
                  // table full: overwrite home slot
                  mem_we    = 1'b1;
                  mem_waddr = home_ff;
                  res_in    = '{status: STAT_FULL, value_out: '0, slot: SlotW'(home_ff)};
                  state_in  = ST_DONE;
               end else begin
                  idx_in    = next_idx;
                  mem_raddr = next_idx;
               end
            end else begin
               if (!rd_data_ff.valid) begin
                  state_in = ST_DONE;
               end else if (rd_data_ff.key == req_ff.key) begin
                  res_in.status = STAT_OK;
                  res_in.slot   = SlotW'(idx_ff);
                  if (req_ff.opcode == OP_LOOKUP) begin
                     res_in.value_out = rd_data_ff.value;
                  end else begin
                     mem_we = 1'b1;
                  end
                  state_in = ST_DONE;
               end else if (wrapped) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in    = next_idx;
                  mem_raddr = next_idx;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      home_ff     <= home_in;
      step_ff     <= step_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[mem_raddr];
   end

   assign clearing    = (state_ff == ST_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> ({1'b0, idx_ff} < SlotLimit))
      else $error("probe index beyond table");

   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_PROBE))
      else $error("table write outside clear or probe");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished transaction not presented");

endmodule

`default_nettype wire

// ----- rtl/double_hash_table_core.sv -----
// Path: front-end hashing pipeline, then the job queue, then the table engine's probe loop.
// The table engine finishes one transaction before it takes the next job, using a single memory read port.
// The front end overlaps key hashing of later transactions with current probing.
// Reset: synchronous; the engine then clears TABLE_SLOTS slots, one per cycle,
// and accepts no transaction until the pass completes.
`timescale 1ns / 1ps
`default_nettype none

module double_hash_table_core import dht_pkg::*; #(
   parameter int TABLE_SLOTS = 1009,
   parameter int STEP_PRIME  = 997
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dht_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dht_rsp_type rsp_payload
);

   localparam int IW   = $clog2(TABLE_SLOTS);
   localparam int JobW = $bits(dht_req_type) + 2 * IW;

   logic            clearing;
   logic            queue_full;
   logic            job_push;
   logic [JobW-1:0] push_data;
   logic            job_pop;
   logic            job_valid;
   logic [JobW-1:0] job_data;

   dht_front #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .STEP_PRIME  (STEP_PRIME)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .clearing    (clearing),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .job_push    (job_push),
      .job_data    (push_data)
   );

   dht_queue #(.WIDTH(JobW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .pop       (job_pop),
      .full      (queue_full),
      .pop_valid (job_valid),
      .pop_data  (job_data)
   );

   dht_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job_data    (job_data),
      .job_pop     (job_pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
